@@ rtl/mavg_pkg.sv @@
// Package for the moving average filter: default sizes, field widths,
// op codes and the state types of the front and back sequencers. No dependencies.
`default_nettype none

package mavg_pkg;

  localparam int MAX_WINDOW_DEF  = 64;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int CFG_W           = 7;
  localparam int CNT_OUT_W       = 7;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic OP_SAMPLE  = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  typedef enum logic {
    F_IDLE,
    F_UPDATE
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_RUN,
    B_DONE
  } back_state_t;

endpackage

`default_nettype wire

@@ rtl/mavg_front.sv @@
// Front end: takes samples and restarts, keeps the sample ring, write position,
// fill count and running sum, and pushes (fill, sum) to the queue. Uses mavg_pkg.
`default_nettype none

module mavg_front #(
  parameter int MAX_WINDOW  = mavg_pkg::MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = mavg_pkg::SAMPLE_BITS_DEF,
  parameter int CNT_W       = $clog2(MAX_WINDOW + 1),
  parameter int SUM_W       = SAMPLE_BITS + $clog2(MAX_WINDOW)
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [mavg_pkg::CFG_W-1:0] cfg_data,
  input  wire logic                      in_tvalid,
  output logic                           in_tready,
  input  wire logic [SAMPLE_BITS-1:0]    in_sample,
  input  wire logic                      in_op,
  output logic                           q_push,
  input  wire logic                      q_full,
  output logic [CNT_W+SUM_W-1:0]         q_wdata
);
  import mavg_pkg::*;

  localparam int POS_W = $clog2(MAX_WINDOW);
  localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  front_state_t state_r, state_nxt;

  logic signed [SAMPLE_BITS-1:0] ring [MAX_WINDOW];
  logic signed [SAMPLE_BITS-1:0] sample_r;
  logic signed [SAMPLE_BITS-1:0] old_r;
  logic [POS_W-1:0]              addr_r;
  logic [POS_W-1:0]              pos_r, pos_nxt;
  logic [CNT_W-1:0]              fill_r, fill_nxt;
  logic [CNT_W-1:0]              win_r;
  logic signed [SUM_W-1:0]       sum_r, sum_nxt;

  logic [CMP_W-1:0] cfg_ext;
  logic [CMP_W-1:0] cfg_sat;
  logic             cfg_wr;
  logic [POS_W-1:0] pos_eff;
  logic [CNT_W-1:0] pos_inc;
  logic             accept;
  logic             restart;
  logic             win_full;

  assign cfg_ready = 1'b1;
  assign cfg_ext   = CMP_W'(cfg_data);
  assign cfg_sat   = (cfg_ext > CMP_W'(MAX_WINDOW)) ? CMP_W'(MAX_WINDOW) : cfg_ext;
  assign cfg_wr    = cfg_valid && (cfg_data != '0);

  assign pos_eff = (CNT_W'(pos_r) >= win_r) ? '0 : pos_r;
  assign accept  = in_tvalid && in_tready;
  assign restart = accept && (in_op == OP_RESTART);

  assign win_full = (fill_r >= win_r);
  assign fill_nxt = win_full ? fill_r : fill_r + 1'b1;
  assign sum_nxt  = sum_r - (win_full ? SUM_W'(old_r) : '0) + SUM_W'(sample_r);
  assign pos_inc  = CNT_W'(addr_r) + 1'b1;
  assign pos_nxt  = (pos_inc >= win_r) ? '0 : POS_W'(pos_inc);
  assign q_wdata  = {fill_nxt, sum_nxt};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE: begin
        if (in_tvalid && (in_op == OP_SAMPLE)) state_nxt = F_UPDATE;
      end
      F_UPDATE: begin
        if (!q_full) state_nxt = F_IDLE;
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    q_push    = 1'b0;
    unique case (state_r)
      F_IDLE:   in_tready = 1'b1;
      F_UPDATE: q_push    = !q_full;
      default: begin
        in_tready = 1'b0;
        q_push    = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r  <= CNT_W'(1);
      pos_r  <= '0;
      fill_r <= '0;
      sum_r  <= '0;
    end else if (cfg_wr) begin
      win_r  <= CNT_W'(cfg_sat);
      pos_r  <= '0;
      fill_r <= '0;
      sum_r  <= '0;
    end else if (restart) begin
      pos_r  <= '0;
      fill_r <= '0;
      sum_r  <= '0;
    end else if (q_push) begin
      pos_r  <= pos_nxt;
      fill_r <= fill_nxt;
      sum_r  <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sample_r <= in_sample;
      addr_r   <= pos_eff;
      old_r    <= ring[pos_eff];
    end
  end

  always_ff @(posedge clk) begin
    if (q_push) ring[addr_r] <= sample_r;
  end

endmodule

`default_nettype wire

@@ rtl/mavg_queue.sv @@
// Short FIFO of (fill count, running sum) between the front end and the divider.
// Depth default from mavg_pkg.
`default_nettype none

module mavg_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = mavg_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic                  empty,
  output logic [WIDTH-1:0]      rdata
);
  import mavg_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr_r] <= wdata;
  end

endmodule

`default_nettype wire

@@ rtl/mavg_div.sv @@
// Back end: serial restoring divider, one quotient bit per cycle, of the running
// sum by the fill count, truncating toward zero; holds the result. Uses mavg_pkg.
`default_nettype none

module mavg_div #(
  parameter int SAMPLE_BITS = mavg_pkg::SAMPLE_BITS_DEF,
  parameter int CNT_W       = 7,
  parameter int SUM_W       = 22
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        q_empty,
  input  wire logic [CNT_W+SUM_W-1:0]      q_rdata,
  output logic                             q_pop,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic signed [SAMPLE_BITS-1:0]    out_mean,
  output logic [mavg_pkg::CNT_OUT_W-1:0]   out_used
);
  import mavg_pkg::*;

  localparam int STEP_W = $clog2(SUM_W);

  back_state_t state_r, state_nxt;

  logic [SUM_W-1:0]  quo_r;
  logic [CNT_W-1:0]  den_r;
  logic [CNT_W-1:0]  rem_r;
  logic [STEP_W-1:0] step_r;
  logic              neg_r;
  logic              valid_r;

  logic [SUM_W-1:0]  q_sum;
  logic [CNT_W-1:0]  q_cnt;
  logic [CNT_W:0]    trial;
  logic              ge;
  logic              load, run, wr_out;
  logic              last_step;
  logic [SAMPLE_BITS-1:0] q_low;

  assign q_sum     = q_rdata[SUM_W-1:0];
  assign q_cnt     = q_rdata[CNT_W+SUM_W-1:SUM_W];
  assign trial     = {rem_r, quo_r[SUM_W-1]};
  assign ge        = (trial >= {1'b0, den_r});
  assign last_step = (step_r == STEP_W'(SUM_W - 1));
  assign q_low     = quo_r[SAMPLE_BITS-1:0];
  assign out_valid = valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: begin
        if (!q_empty) state_nxt = B_RUN;
      end
      B_RUN: begin
        if (last_step) state_nxt = B_DONE;
      end
      B_DONE: begin
        if (!valid_r || out_ready) state_nxt = B_IDLE;
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    load   = 1'b0;
    run    = 1'b0;
    wr_out = 1'b0;
    unique case (state_r)
      B_IDLE: load   = !q_empty;
      B_RUN:  run    = 1'b1;
      B_DONE: wr_out = !valid_r || out_ready;
      default: begin
        load   = 1'b0;
        run    = 1'b0;
        wr_out = 1'b0;
      end
    endcase
  end

  assign q_pop = load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (wr_out) begin
        valid_r <= 1'b1;
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      neg_r  <= q_sum[SUM_W-1];
      quo_r  <= q_sum[SUM_W-1] ? (~q_sum + 1'b1) : q_sum;
      den_r  <= q_cnt;
      rem_r  <= '0;
      step_r <= '0;
    end else if (run) begin
      rem_r  <= ge ? CNT_W'(trial - {1'b0, den_r}) : CNT_W'(trial);
      quo_r  <= {quo_r[SUM_W-2:0], ge};
      step_r <= step_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_out) begin
      out_mean <= neg_r ? signed'(~q_low + 1'b1) : signed'(q_low);
      out_used <= CNT_OUT_W'(den_r);
    end
  end

endmodule

`default_nettype wire

@@ rtl/moving_average_filter.sv @@
// Moving average filter top level: front end, (fill, sum) queue, serial divider.
// The front end can take a new sample while the one-bit-per-cycle divider is still
// working on earlier ones, as long as the queue has room; a restart gives no result.
// Reset: window size 1, fill count, sum and position cleared; ring not cleared.
`default_nettype none

module moving_average_filter #(
  parameter int MAX_WINDOW  = mavg_pkg::MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = mavg_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [mavg_pkg::CFG_W-1:0]          cfg_data,   // window_size
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]    in_tdata,   // sample, zero pad
  input  wire logic [0:0]                          in_tuser,   // op
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic [((SAMPLE_BITS+mavg_pkg::CNT_OUT_W+7)/8)*8-1:0]
                                                   out_tdata   // mean, samples_used, zero pad
);
  import mavg_pkg::*;

  localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W  = SAMPLE_BITS + $clog2(MAX_WINDOW);
  localparam int Q_W    = CNT_W + SUM_W;

  logic                          q_push, q_full, q_pop, q_empty;
  logic [Q_W-1:0]                q_wdata, q_rdata;
  logic signed [SAMPLE_BITS-1:0] mean;
  logic [CNT_OUT_W-1:0]          used;

  mavg_front #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS),
    .CNT_W       (CNT_W),
    .SUM_W       (SUM_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_sample (in_tdata[SAMPLE_BITS-1:0]),
    .in_op     (in_tuser[0]),
    .q_push    (q_push),
    .q_full    (q_full),
    .q_wdata   (q_wdata)
  );

  mavg_queue #(
    .WIDTH (Q_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .empty (q_empty),
    .rdata (q_rdata)
  );

  mavg_div #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .CNT_W       (CNT_W),
    .SUM_W       (SUM_W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_rdata   (q_rdata),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_mean  (mean),
    .out_used  (used)
  );

  always_comb begin
    out_tdata = '0;
    out_tdata[SAMPLE_BITS-1:0] = mean;
    out_tdata[SAMPLE_BITS +: CNT_OUT_W] = used;
  end

`ifndef NO_ASSERTIONS
  a_used_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[SAMPLE_BITS +: CNT_OUT_W] != '0))
    else $error("result with zero samples used");

  a_restart_no_push: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser[0] == OP_RESTART)) |=> !q_push)
    else $error("restart pushed a queue entry");

  a_push_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !in_tready)
    else $error("input taken while front end updating");
`endif

endmodule

`default_nettype wire

@@ bench/tb.sv @@
// Self-checking bench for moving_average_filter: streams samples and restarts, changes the
// window size between phases and checks every mean and fill count against an internal model.
// Depends on mavg_pkg and moving_average_filter.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mavg_pkg::*;

  localparam int ITEM_GOAL   = 1900;
  localparam int SETTLE      = 40;
  localparam int STALL_LIMIT = 2000;
  localparam int IDLE_PCT    = 34;

  typedef enum int {MIX_FULL, MIX_EXTREME, MIX_SMALL, MIX_ALL_MAX, MIX_ALL_MIN} mix_t;

  typedef struct {
    logic signed [15:0] mean;
    logic [6:0]         used;
  } mean_result_t;

  class mean_tracker;
    logic signed [15:0] ring [MAX_WINDOW_DEF];
    int unsigned        wr_pos;
    int unsigned        filled;
    int unsigned        window;
    longint             total;
    mean_result_t       pending [$];
    int                 errors;

    function new();
      window = 1;
      errors = 0;
      clear_filter();
    endfunction

    function void clear_filter();
      wr_pos = 0;
      filled = 0;
      total  = 0;
    endfunction

    function void set_window(logic [CFG_W-1:0] raw);
      if (raw == 0) return;
      window = (raw > MAX_WINDOW_DEF) ? MAX_WINDOW_DEF : raw;
      clear_filter();
    endfunction

    function void note_item(logic op, logic signed [15:0] s);
      int unsigned  pos;
      mean_result_t r;
      if (op == OP_RESTART) begin
        clear_filter();
        return;
      end
      pos = (wr_pos >= window) ? 0 : wr_pos;
      if (filled < window) filled++;
      else total -= longint'(ring[pos]);
      total += longint'(s);
      ring[pos] = s;
      pos++;
      wr_pos = (pos >= window) ? 0 : pos;
      r.mean = 16'(total / longint'(filled));
      r.used = 7'(filled);
      pending.push_back(r);
    endfunction

    function void check_mean(logic signed [15:0] mean, logic [6:0] used);
      mean_result_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual mean %0d used %0d",
                 $time, mean, used);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (mean !== e.mean) begin
        $display("%0t: mean mismatch, expected %0d, actual %0d", $time, e.mean, mean);
        errors++;
      end
      if (used !== e.used) begin
        $display("%0t: samples_used mismatch, expected %0d, actual %0d", $time, e.used, used);
        errors++;
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [CFG_W-1:0]  cfg_data;
  logic              in_tvalid;
  logic              in_tready;
  logic [15:0]       in_tdata;   // sample
  logic [0:0]        in_tuser;   // op
  logic              out_tvalid;
  logic              out_tready;
  logic [23:0]       out_tdata;  // mean, samples_used, zero pad

  mean_tracker sb = new();
  logic        steady;
  int          items;
  int          idle_cycles;

  moving_average_filter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      out_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // transfer monitor, scoreboard and watchdog
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if (rst_n) begin
        if (cfg_valid && cfg_ready) sb.set_window(cfg_data);
        if (in_tvalid && in_tready) sb.note_item(in_tuser[0], in_tdata);
        if (out_tvalid && out_tready) sb.check_mean(out_tdata[15:0], out_tdata[22:16]);
        if ((cfg_valid && cfg_ready) || (in_tvalid && in_tready) || (out_tvalid && out_tready))
          idle_cycles = 0;
        else
          idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
          $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
          $display("tb failed");
          $finish;
        end
      end
    end
  end

  function automatic logic signed [15:0] pick_sample(mix_t mix);
    case (mix)
      MIX_EXTREME: begin
        case ($urandom_range(4))
          0: return 16'sh7fff;
          1: return 16'sh8000;
          2: return -16'sd1;
          3: return 16'sd0;
          default: return 16'sd1;
        endcase
      end
      MIX_SMALL:   return 16'(int'($urandom_range(16)) - 8);
      MIX_ALL_MAX: return 16'sh7fff;
      MIX_ALL_MIN: return 16'sh8000;
      default:     return 16'($urandom);
    endcase
  endfunction

  task automatic send_item(input logic op, input logic [15:0] s);
    if (!steady) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid   <= 1'b1;
    in_tuser[0] <= op;
    in_tdata    <= s;
    do @(posedge clk); while (!in_tready);
    items++;
  endtask

  // hold the sender until every expected mean is back, then let the pipe settle
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_window(input logic [CFG_W-1:0] raw);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= raw;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int               phase;
    int               len;
    mix_t             mix;
    logic [CFG_W-1:0] raw;
    rst_n     = 1'b0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    steady    = 1'b0;
    items     = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // window of one after reset: the mean is the sample itself
    send_item(OP_SAMPLE, 16'h7fff);
    send_item(OP_SAMPLE, 16'h8000);
    send_item(OP_SAMPLE, 16'hffff);
    send_item(OP_SAMPLE, 16'h0000);
    send_item(OP_RESTART, 16'hffff);
    send_item(OP_SAMPLE, 16'd5);
    // zero size is dropped, no restart
    write_window(7'd0);
    send_item(OP_SAMPLE, 16'd7);
    // oversize saturates to the maximum window
    write_window(7'h7f);
    send_item(OP_SAMPLE, 16'h8000);
    send_item(OP_SAMPLE, 16'h7fff);
    send_item(OP_SAMPLE, 16'hffff);
    send_item(OP_RESTART, 16'h0000);
    send_item(OP_SAMPLE, -16'sd7);
    send_item(OP_SAMPLE, 16'd2);
    // short window wraps the ring
    write_window(7'd3);
    send_item(OP_SAMPLE, 16'd1);
    send_item(OP_SAMPLE, 16'd2);
    send_item(OP_SAMPLE, 16'd3);
    send_item(OP_SAMPLE, 16'd4);
    send_item(OP_SAMPLE, 16'd5);
    send_item(OP_SAMPLE, 16'h8000);

    phase = 0;
    while (items < ITEM_GOAL) begin
      case ($urandom_range(5))
        0: raw = 7'd1;
        1: raw = 7'd2;
        2: raw = 7'd64;
        3: raw = 7'($urandom_range(127, 65));
        4: raw = 7'd0;
        default: raw = 7'($urandom_range(64, 1));
      endcase
      steady = (phase == 3);
      write_window(raw);
      mix = mix_t'($urandom_range(4));
      len = $urandom_range(180, 40);
      repeat (len) begin
        if ($urandom_range(99) < 3) send_item(OP_RESTART, 16'($urandom));
        else send_item(OP_SAMPLE, pick_sample(mix));
        if ($urandom_range(199) == 0) drain_results();
      end
      phase++;
    end
    steady = 1'b0;

    drain_results();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end
endmodule
